// ===== rtl/core/smr_pkg.sv =====
// Shared types, widths, register indexes and constant tables of the
// sinusoid model and residual core. No dependencies.

package smr_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  localparam int PHASE_W     = 16;
  localparam int ANGLE_W     = 32;
  localparam int XY_W        = 34;
  localparam int Z_W         = 33;
  localparam int PROD_W      = VALUE_WIDTH + XY_W;
  localparam int SAT_W       = VALUE_WIDTH + 5;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET    = 3'd3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [XY_W-1:0]        xy_t;
  typedef logic signed [Z_W-1:0]         z_t;
  typedef logic signed [SAT_W-1:0]       wide_t;

  localparam xy_t GAIN_Q30 = 34'sd652032874;

  localparam wide_t SAT_HI = {{(SAT_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam wide_t SAT_LO = ~SAT_HI;

  function automatic logic [ANGLE_W-1:0] atan_turns(input int idx);
    logic [ANGLE_W-1:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051D;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Low 32 bits of a value after sign extension; enough for the phase product.
  function automatic logic [31:0] low_word(input value_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic value_t saturate(input wide_t v);
    value_t r;
    if (v > SAT_HI) begin
      r = VALUE_WIDTH'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = VALUE_WIDTH'(SAT_LO);
    end else begin
      r = VALUE_WIDTH'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sinusoid_model_residual_core.sv =====
// Sinusoid model and residual core: m = C + A*sin(2*pi*(F*t + P)), r = y - m.
// A result passes the phase front end, the CORDIC stages, the back end and the output register.
// Throughput: one item per cycle while in_stall is low, set by the registered CORDIC stages.
// An output skid register takes one result under stall; in_stall is that register's fill.
// Reset is synchronous: valid bits clear and the registers return to A=1.0, F=1.0, P=0, C=0.

module sinusoid_model_residual_core
  import smr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  value_t                 time_value,
  input  value_t                 measured_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output value_t                 model_value,
  output value_t                 residual,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  value_t                 cfg_data
);

  value_t             amplitude;
  value_t             frequency;
  logic [PHASE_W-1:0] phase_turns;
  value_t             offset;

  logic   en;
  logic   ph_valid;
  z_t     ph_angle;
  value_t ph_meas;
  logic   cr_valid;
  xy_t    cr_sine;
  value_t cr_meas;
  logic   pipe_valid;
  value_t pipe_model;
  value_t pipe_resid;
  logic   deliver;

  logic   skid_valid;
  value_t skid_model;
  value_t skid_resid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= VALUE_WIDTH'(65536);
      frequency   <= VALUE_WIDTH'(65536);
      phase_turns <= '0;
      offset      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AMPLITUDE: amplitude   <= cfg_data;
        REG_FREQUENCY: frequency   <= cfg_data;
        REG_PHASE:     phase_turns <= cfg_data[PHASE_W-1:0];
        REG_OFFSET:    offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  smr_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .time_value  (time_value),
    .meas_in     (measured_value),
    .frequency   (frequency),
    .phase_turns (phase_turns),
    .out_valid   (ph_valid),
    .angle       (ph_angle),
    .meas_out    (ph_meas)
  );

  smr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ph_valid),
    .angle     (ph_angle),
    .meas_in   (ph_meas),
    .out_valid (cr_valid),
    .sine      (cr_sine),
    .meas_out  (cr_meas)
  );

  smr_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (cr_valid),
    .sine        (cr_sine),
    .meas_in     (cr_meas),
    .amplitude   (amplitude),
    .offset      (offset),
    .out_valid   (pipe_valid),
    .model_value (pipe_model),
    .residual    (pipe_resid)
  );

  assign deliver = pipe_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= deliver;
      end
    end else if (!out_valid) begin
      out_valid <= deliver;
    end else if (deliver) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && skid_valid) begin
      model_value <= skid_model;
      residual    <= skid_resid;
    end else if ((!out_valid || !out_stall) && deliver) begin
      model_value <= pipe_model;
      residual    <= pipe_resid;
    end
    if (out_valid && out_stall && deliver) begin
      skid_model <= pipe_model;
      skid_resid <= pipe_resid;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid register did not move into the output register");

  a_no_deliver_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !deliver)
    else $error("pipeline delivered a result while the skid register was full");
`endif

endmodule

// ===== rtl/core/smr_phase.sv =====
// Phase front end: fraction of F*t plus the phase offset, folded into the
// quarter-turn range as a CORDIC angle. Two register stages. Uses smr_pkg.

module smr_phase
  import smr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  value_t             time_value,
  input  value_t             meas_in,
  input  value_t             frequency,
  input  logic [PHASE_W-1:0] phase_turns,
  output logic               out_valid,
  output z_t                 angle,
  output value_t             meas_out
);

  logic [31:0]        prod;
  logic               valid1;
  logic [PHASE_W-1:0] frac1;
  value_t             meas1;
  logic [PHASE_W-1:0] phase_sum;
  logic [ANGLE_W-1:0] turns;
  logic [ANGLE_W-1:0] folded;

  assign prod = low_word(frequency) * low_word(time_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac1 <= prod[31:16];
      meas1 <= meas_in;
    end
  end

  assign phase_sum = frac1 + phase_turns;
  assign turns     = {phase_sum, {(ANGLE_W-PHASE_W){1'b0}}};

  // Outside a quarter turn, sin(x) = sin(1/2 - x) brings the angle back in.
  always_comb begin
    if (turns[ANGLE_W-1] ^ turns[ANGLE_W-2]) begin
      folded = 32'h80000000 - turns;
    end else begin
      folded = turns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle    <= Z_W'(signed'(folded));
      meas_out <= meas1;
    end
  end

endmodule

// ===== rtl/core/smr_cordic.sv =====
// Rotation-mode CORDIC producing the sine in Q4.30, one register stage per
// iteration. Uses smr_pkg.

module smr_cordic
  import smr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  z_t     angle,
  input  value_t meas_in,
  output logic   out_valid,
  output xy_t    sine,
  output value_t meas_out
);

  logic   vld [0:NUM_STAGES];
  xy_t    xs  [0:NUM_STAGES];
  xy_t    ys  [0:NUM_STAGES];
  z_t     zs  [0:NUM_STAGES];
  value_t ms  [0:NUM_STAGES];

  assign vld[0] = in_valid;
  assign xs[0]  = GAIN_Q30;
  assign ys[0]  = '0;
  assign zs[0]  = angle;
  assign ms[0]  = meas_in;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    localparam logic [Z_W-1:0] ATAN_I = Z_W'(atan_turns(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms[i+1] <= ms[i];
        if (!zs[i][Z_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - signed'(ATAN_I);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + signed'(ATAN_I);
        end
      end
    end
  end

  assign out_valid = vld[NUM_STAGES];
  assign sine      = ys[NUM_STAGES];
  assign meas_out  = ms[NUM_STAGES];

endmodule

// ===== rtl/core/smr_scale.sv =====
// Back end: amplitude times sine with round half up, offset add, and the
// saturated model value and residual. Three register stages. Uses smr_pkg.

module smr_scale
  import smr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  xy_t    sine,
  input  value_t meas_in,
  input  value_t amplitude,
  input  value_t offset,
  output logic   out_valid,
  output value_t model_value,
  output value_t residual
);

  logic                     valid1;
  logic                     valid2;
  logic signed [PROD_W-1:0] prod1;
  value_t                   meas1;
  value_t                   meas2;
  value_t                   model2;
  logic signed [PROD_W-1:0] rounded;
  wide_t                    model_sum;
  wide_t                    resid_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= PROD_W'(amplitude) * PROD_W'(sine);
      meas1 <= meas_in;
    end
  end

  assign rounded   = (prod1 + PROD_W'(2**29)) >>> 30;
  assign model_sum = SAT_W'(rounded) + SAT_W'(offset);

  always_ff @(posedge clk) begin
    if (en) begin
      model2 <= saturate(model_sum);
      meas2  <= meas1;
    end
  end

  assign resid_diff = SAT_W'(meas2) - SAT_W'(model2);

  always_ff @(posedge clk) begin
    if (en) begin
      model_value <= model2;
      residual    <= saturate(resid_diff);
    end
  end

endmodule

// ===== bench/tb_sinusoid_model_residual_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sinusoid_model_residual_core: a directed table and then
// random samples under random register settings, checked against a local predictor or known table values.
// Depends on smr_pkg and the core RTL.

module tb_sinusoid_model_residual_core;
  import smr_pkg::*;

  localparam int SAMPLE_TARGET = 1250;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int TABLE_STAGES  = 24;

  localparam longint CORDIC_GAIN  = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint ROUND_HALF   = 64'sd536870912;

  localparam value_t VALUE_MAX = 32'sh7FFFFFFF;
  localparam value_t VALUE_MIN = 32'sh80000000;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

  localparam logic [31:0] ROTATION_TURNS [TABLE_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    value_t model;
    value_t resid;
  } fit_point_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    value_t                 data;
    value_t                 t;
    value_t                 y;
    bit                     known;
    fit_point_t             result;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  value_t                 time_value = '0;
  value_t                 measured_value = '0;
  logic                   out_valid;
  logic                   out_stall;
  value_t                 model_value;
  value_t                 residual;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  value_t                 cfg_data = '0;

  value_t      amp_q = 32'sd65536;
  value_t      freq_q = 32'sd65536;
  logic [15:0] phase_q = 16'h0000;
  value_t      offset_q = '0;

  fit_point_t pending_results[$];
  plan_row_t  plan[$];
  bit         known_q = 1'b0;
  fit_point_t known_result = '0;
  bit         no_idle = 1'b0;

  int errors = 0;
  int results_checked = 0;
  int samples_taken = 0;
  int reg_writes = 0;
  int idle_count = 0;

  sinusoid_model_residual_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .time_value    (time_value),
    .measured_value(measured_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .model_value   (model_value),
    .residual      (residual),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic value_t clamp_value(input longint v);
    if (v > longint'(VALUE_MAX)) return VALUE_MAX;
    if (v < longint'(VALUE_MIN)) return VALUE_MIN;
    return value_t'(v);
  endfunction

  function automatic fit_point_t predict_point(input value_t t, input value_t y);
    logic signed [63:0] prod;
    logic [15:0]        turn;
    logic [31:0]        angle;
    longint             z;
    longint             xr;
    longint             yr;
    longint             xn;
    longint             scaled;
    int                 stages;
    int                 i;
    fit_point_t         p;
    stages = (CORDIC_STAGES > TABLE_STAGES) ? TABLE_STAGES : CORDIC_STAGES;
    prod = longint'(freq_q) * longint'(t);
    turn = prod[31:16] + phase_q;
    angle = {turn, 16'h0000};
    z = longint'($signed(angle));
    // Angles outside the right half-plane are mirrored about a quarter turn.
    if (z >= QUARTER_TURN || z < -QUARTER_TURN) begin
      angle = 32'h80000000 - angle;
      z = longint'($signed(angle));
    end
    xr = CORDIC_GAIN;
    yr = 0;
    for (i = 0; i < stages; i++) begin
      if (z >= 0) begin
        xn = xr - (yr >>> i);
        yr = yr + (xr >>> i);
        z = z - longint'(ROTATION_TURNS[i]);
      end else begin
        xn = xr + (yr >>> i);
        yr = yr - (xr >>> i);
        z = z + longint'(ROTATION_TURNS[i]);
      end
      xr = xn;
    end
    scaled = (longint'(amp_q) * yr + ROUND_HALF) >>> 30;
    p.model = clamp_value(longint'(offset_q) + scaled);
    p.resid = clamp_value(longint'(y) - longint'(p.model));
    return p;
  endfunction

  function automatic value_t random_value();
    value_t v;
    case ($urandom_range(0, 7))
      0: v = VALUE_MAX;
      1: v = VALUE_MIN;
      2: v = value_t'($urandom_range(0, 32'h80000)) - 32'sh40000;
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx, input value_t data);
    plan_row_t r;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.data = data;
    r.t = '0;
    r.y = '0;
    r.known = 1'b0;
    r.result = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_sample(input value_t t, input value_t y, input bit known,
                                      input value_t m, input value_t res);
    plan_row_t r;
    r.kind = ROW_SAMPLE;
    r.index = '0;
    r.data = '0;
    r.t = t;
    r.y = y;
    r.known = known;
    r.result.model = m;
    r.result.resid = res;
    plan.push_back(r);
  endfunction

  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input value_t data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AMPLITUDE: amp_q = data;
      REG_FREQUENCY: freq_q = data;
      REG_PHASE:     phase_q = data[15:0];
      REG_OFFSET:    offset_q = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input value_t t, input value_t y, input bit known,
                             input fit_point_t result);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    time_value = t;
    measured_value = y;
    known_q = known;
    known_result = result;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_results.push_back(known_q ? known_result
                                        : predict_point(time_value, measured_value));
      samples_taken++;
    end
  end

  always @(posedge clk) begin
    fit_point_t exp_pt;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected: model %h residual %h",
                 $time, model_value, residual);
        errors++;
      end else begin
        exp_pt = pending_results.pop_front();
        results_checked++;
        if (model_value !== exp_pt.model) begin
          $display("%0t: model_value expected %h actual %h", $time, exp_pt.model, model_value);
          errors++;
        end
        if (residual !== exp_pt.resid) begin
          $display("%0t: residual expected %h actual %h", $time, exp_pt.resid, residual);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int stall_cycles;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      stall_cycles = no_idle ? 0 : $urandom_range(0, 7);
      if (stall_cycles > 0) begin
        out_stall = 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int     phase_items;
    value_t t;
    value_t y;

    plan_sample(32'sh00000000, 32'sh00000000, 1'b0, '0, '0);
    plan_sample(32'sh00004000, 32'sh00010000, 1'b0, '0, '0);
    plan_sample(VALUE_MAX, VALUE_MAX, 1'b0, '0, '0);
    plan_sample(VALUE_MIN, VALUE_MIN, 1'b0, '0, '0);
    plan_sample(32'shFFFFFFFF, 32'shFFFFFFFF, 1'b0, '0, '0);
    plan_sample(32'sh00008000, 32'sh00000000, 1'b0, '0, '0);

    plan_write(REG_AMPLITUDE, 32'sh00000000);
    plan_write(REG_OFFSET, 32'sh12345678);
    plan_sample(32'sh00001234, 32'sh12345678, 1'b1, 32'sh12345678, 32'sh00000000);
    plan_sample(VALUE_MAX, VALUE_MIN, 1'b1, 32'sh12345678, VALUE_MIN);

    plan_write(REG_AMPLITUDE, VALUE_MAX);
    plan_write(REG_OFFSET, VALUE_MAX);
    plan_write(REG_FREQUENCY, 32'sh00000000);
    plan_write(REG_PHASE, 32'sh00004000);
    plan_sample(32'sh00000000, VALUE_MIN, 1'b1, VALUE_MAX, VALUE_MIN);
    plan_sample(32'sh00005555, VALUE_MAX, 1'b1, VALUE_MAX, 32'sh00000000);

    plan_write(REG_AMPLITUDE, VALUE_MIN);
    plan_write(REG_OFFSET, VALUE_MIN);
    plan_sample(32'sh00000000, VALUE_MAX, 1'b1, VALUE_MIN, VALUE_MAX);
    plan_sample(VALUE_MAX, VALUE_MIN, 1'b1, VALUE_MIN, 32'sh00000000);

    plan_write(REG_AMPLITUDE, 32'shFFFF0000);
    plan_write(REG_OFFSET, 32'sh00000000);
    plan_write(REG_FREQUENCY, 32'shFFFF0000);
    plan_write(REG_PHASE, 32'sh0000C000);
    plan_sample(32'sh00004000, 32'sh00000000, 1'b0, '0, '0);
    plan_sample(32'shFFFFC000, 32'sh00000100, 1'b0, '0, '0);
    plan_sample(VALUE_MAX, 32'sh00000000, 1'b0, '0, '0);

    plan_write(REG_UNMAPPED_FIRST, 32'sh00000000);
    plan_write(REG_UNMAPPED_LAST, 32'shFFFFFFFF);
    plan_sample(32'sh00002000, 32'sh00020000, 1'b0, '0, '0);

    plan_write(REG_FREQUENCY, VALUE_MAX);
    plan_write(REG_PHASE, 32'sh0000FFFF);
    plan_write(REG_AMPLITUDE, VALUE_MAX);
    plan_write(REG_OFFSET, VALUE_MIN);
    plan_sample(VALUE_MAX, 32'sh00000000, 1'b0, '0, '0);
    plan_sample(VALUE_MIN, VALUE_MAX, 1'b0, '0, '0);

    plan_write(REG_FREQUENCY, VALUE_MIN);
    plan_write(REG_PHASE, 32'sh00008000);
    plan_sample(32'sh00010001, VALUE_MIN, 1'b0, '0, '0);
    plan_sample(32'shFFFFFFFF, 32'sh00012345, 1'b0, '0, '0);

    plan_write(REG_FREQUENCY, 32'sh00000000);
    plan_write(REG_AMPLITUDE, 32'sh00010000);
    plan_write(REG_OFFSET, 32'sh00000000);
    plan_write(REG_PHASE, 32'sh00003FFF);
    plan_sample(32'sh00000000, 32'sh00000000, 1'b0, '0, '0);
    plan_write(REG_PHASE, 32'sh0000C001);
    plan_sample(32'sh00000000, 32'sh00000000, 1'b0, '0, '0);
    plan_write(REG_PHASE, 32'sh0000BFFF);
    plan_sample(32'sh00000000, 32'sh00000000, 1'b0, '0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_sample(plan[i].t, plan[i].y, plan[i].known, plan[i].result);
      end
    end

    while (samples_taken < SAMPLE_TARGET) begin
      settle();
      write_reg(REG_AMPLITUDE, random_value());
      write_reg(REG_FREQUENCY, random_value());
      write_reg(REG_PHASE, value_t'($urandom));
      write_reg(REG_OFFSET, random_value());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                  value_t'($urandom));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(60, 140);
      repeat (phase_items) begin
        t = random_value();
        y = random_value();
        send_sample(t, y, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results from %0d samples with %0d register writes,", results_checked,
             samples_taken, reg_writes);
    $display("including saturated outputs, negative parameters and unmapped register writes.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
